// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ON_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ggc_pkg.sv =====
// Shared types, constants and helpers of the greedy graph coloring block.
`timescale 1ns / 1ps
`default_nettype none

package ggc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_COLORS   = 64;
   localparam int VERTEX_W     = 10;
   localparam int COLOR_W      = 6;
   localparam int COUNT_W      = 7;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int EPOCH_W      = 4;
   localparam int WORD_W       = 1 + EPOCH_W + COLOR_W;
   localparam int FIFO_DEPTH   = 2;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [VERTEX_W-1:0] neighbor;
      logic                mark;
      logic                last;
      logic                start;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic               flag;
      logic [EPOCH_W-1:0] epoch;
      logic [COLOR_W-1:0] color;
   } entry_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_LOOKUP,
      BK_WRAP,
      BK_FINISH
   } back_state_type;

   function automatic logic in_range(input logic [VERTEX_W-1:0] v);
      return 32'(v) < MAX_VERTICES;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ggc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ggc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ggc_front.sv =====
// Front end: transaction acceptance and neighbor classification.
`timescale 1ns / 1ps
`default_nettype none

module ggc_front import ggc_pkg::*; (
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [VERTEX_W-1:0] req_vertex,
   input  wire logic [VERTEX_W-1:0] req_neighbor,
   input  wire logic                req_neighbor_valid,
   input  wire logic                req_last_of_vertex,
   input  wire logic                req_start_run,
   input  wire queue_status_type    q_status,
   input  wire back_status_type     bk_status,
   output logic                     push,
   output cmd_type                  cmd
);

   always_comb begin
      busy         = q_status.full | bk_status.clearing;
      push         = start & ~busy;
      cmd.vertex   = req_vertex;
      cmd.neighbor = req_neighbor;
      // self-loops, empty items and out-of-range neighbors never mark a color
      cmd.mark     = req_neighbor_valid & (req_neighbor != req_vertex) &
                     in_range(req_neighbor);
      cmd.last     = req_last_of_vertex;
      cmd.start    = req_start_run;
   end

endmodule

`default_nettype wire

// ===== rtl/core/ggc_queue.sv =====
// Command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module ggc_queue import ggc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire cmd_type     cmd,
   input  wire logic        pop,
   output cmd_type          head,
   output queue_status_type status
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      status.empty = (cnt_ff == '0);
      status.full  = (cnt_ff == CNT_W'(FIFO_DEPTH));
      head         = mem_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      cnt_in       = cnt_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ggc_back.sv =====
// Back end: color table lookup, used-color mask, first-fit pick and response.
`timescale 1ns / 1ps
`default_nettype none

module ggc_back import ggc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire cmd_type          head,
   output logic                  pop,
   output back_status_type       status,
   output logic                  rsp_valid,
   output logic [VERTEX_W-1:0]   rsp_colored_vertex,
   output logic [COLOR_W-1:0]    rsp_color,
   output logic [COUNT_W-1:0]    rsp_colors_used,
   output logic                  rsp_overflow
);

   back_state_type         state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [EPOCH_W-1:0]     epoch_ff, epoch_in;
   logic [MAX_COLORS-1:0]  mask_ff, mask_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   cmd_type                cmd_ff, cmd_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic [COLOR_W-1:0]     rsp_color_ff, rsp_color_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   entry_type              wr_entry;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [WORD_W-1:0]      rd_word;
   entry_type              rd_entry;

   logic                   found;
   logic [COLOR_W-1:0]     pick;

   ggc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_VERTICES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (WORD_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);

   // first free color, lowest index wins
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = MAX_COLORS - 1; i >= 0; i--) begin
         if (!mask_ff[i]) begin
            found = 1'b1;
            pick  = COLOR_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      epoch_in      = epoch_ff;
      mask_in       = mask_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_entry      = '0;
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(head.neighbor);
      status.clearing = (state_ff == BK_INIT) || (state_ff == BK_WRAP);

      case (state_ff)
         BK_INIT, BK_WRAP: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_VERTICES - 1) begin
               clr_in = '0;
               if (state_ff == BK_INIT) begin
                  state_in = BK_IDLE;
               end else begin
                  state_in = cmd_ff.last ? BK_FINISH : BK_IDLE;
               end
            end
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               if (head.start) begin
                  // new run: every vertex reads as uncolored, so no lookup
                  mask_in  = '0;
                  count_in = '0;
                  epoch_in = epoch_ff + 1'b1;
                  if (epoch_ff == '1) begin
                     state_in = BK_WRAP;
                  end else if (head.last) begin
                     state_in = BK_FINISH;
                  end
               end else if (head.mark) begin
                  rd_en    = 1'b1;
                  state_in = BK_LOOKUP;
               end else if (head.last) begin
                  state_in = BK_FINISH;
               end
            end
         end
         BK_LOOKUP: begin
            if (rd_entry.flag && (rd_entry.epoch == epoch_ff) &&
                (32'(rd_entry.color) < MAX_COLORS)) begin
               mask_in = mask_ff | (MAX_COLORS'(1) << rd_entry.color);
            end
            state_in = cmd_ff.last ? BK_FINISH : BK_IDLE;
         end
         BK_FINISH: begin
            if (in_range(cmd_ff.vertex)) begin
               wr_en    = 1'b1;
               wr_addr  = ADDR_W'(cmd_ff.vertex);
               wr_entry.flag  = found;
               wr_entry.epoch = epoch_ff;
               wr_entry.color = found ? pick : '0;
            end
            if (found && ((COUNT_W'(pick) + 1'b1) > count_ff)) begin
               count_in = COUNT_W'(pick) + 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = cmd_ff.vertex;
            rsp_color_in  = found ? pick : '0;
            rsp_count_in  = count_in;
            rsp_ovf_in    = ~found;
            mask_in       = '0;
            state_in      = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         clr_ff       <= '0;
         epoch_ff     <= '0;
         mask_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         epoch_ff     <= epoch_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_colored_vertex = rsp_vertex_ff;
   assign rsp_color          = rsp_color_ff;
   assign rsp_colors_used    = rsp_count_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/core/greedy_graph_coloring.sv =====
// Top level of the first-fit greedy graph coloring block.
//
//   channel   handshake          ports
//   request   start / busy       req_vertex, req_neighbor, req_neighbor_valid,
//                                req_last_of_vertex, req_start_run
//   response  rsp_valid strobe   rsp_colored_vertex, rsp_color, rsp_colors_used,
//                                rsp_overflow
//
// A neighbor transaction is popped in BK_IDLE, which issues the color RAM
// read, then updates the mask in BK_LOOKUP on the registered read port; one
// that cannot mark ends in BK_IDLE. A last-of-vertex transaction adds BK_FINISH
// for the first-fit pick and color write, which registers the response strobe.
// After reset a clearing pass over all 1024 color RAM entries holds busy high;
// every 16th run start repeats that pass before its transaction proceeds.
// busy is high while the 2-entry command queue is full; responses cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module greedy_graph_coloring import ggc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [VERTEX_W-1:0] req_vertex,
   input  wire logic [VERTEX_W-1:0] req_neighbor,
   input  wire logic                req_neighbor_valid,
   input  wire logic                req_last_of_vertex,
   input  wire logic                req_start_run,
   output logic                     rsp_valid,
   output logic [VERTEX_W-1:0]      rsp_colored_vertex,
   output logic [COLOR_W-1:0]       rsp_color,
   output logic [COUNT_W-1:0]       rsp_colors_used,
   output logic                     rsp_overflow
);

   queue_status_type q_status;
   back_status_type  bk_status;
   logic             push;
   logic             pop;
   cmd_type          cmd;
   cmd_type          head;

   ggc_front u_front (
      .start              (start),
      .busy               (busy),
      .req_vertex         (req_vertex),
      .req_neighbor       (req_neighbor),
      .req_neighbor_valid (req_neighbor_valid),
      .req_last_of_vertex (req_last_of_vertex),
      .req_start_run      (req_start_run),
      .q_status           (q_status),
      .bk_status          (bk_status),
      .push               (push),
      .cmd                (cmd)
   );

   ggc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd    (cmd),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   ggc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .head               (head),
      .pop                (pop),
      .status             (bk_status),
      .rsp_valid          (rsp_valid),
      .rsp_colored_vertex (rsp_colored_vertex),
      .rsp_color          (rsp_color),
      .rsp_colors_used    (rsp_colors_used),
      .rsp_overflow       (rsp_overflow)
   );

   `ASSERT_ON_CLK(a_rsp_spacing, clock, reset, rsp_valid |=> !rsp_valid, "responses too close")
   `ASSERT_ON_CLK(a_ovf_color, clock, reset, rsp_valid && rsp_overflow |-> rsp_color == '0, "overflow with nonzero color")
   `ASSERT_ON_CLK(a_count_bound, clock, reset, rsp_valid && !rsp_overflow |-> 32'(rsp_color) < 32'(rsp_colors_used), "color beyond colors_used")
   `ASSERT_NEVER(a_pop_clear, clock, reset, pop && bk_status.clearing, "queue pop during clearing pass")

endmodule

`default_nettype wire
